[hdl/dtc_pkg.sv]
// Package for the date stamp to calendar fields block.
// Holds field widths, calendar constants, the sequencer state type and
// small calendar helper functions. No dependencies.
package dtc_pkg;

  localparam int unsigned DAY_W  = 15;
  localparam int unsigned MOD_W  = 11;
  localparam int unsigned TICK_W = 12;
  localparam int unsigned BLEN_W = 8;
  localparam int unsigned TZ_W   = 12;
  localparam int unsigned YEAR_W = 11;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned DOM_W  = 5;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned WDAY_W = 3;
  localparam int unsigned ACC_W  = 18;

  localparam logic [MOD_W-1:0]  MIN_PER_DAY = 11'd1440;
  localparam logic [MOD_W-1:0]  MOD_MAX     = 11'd1439;
  localparam logic [BLEN_W-1:0] BLEN_MIN    = 8'd30;
  localparam logic [YEAR_W-1:0] EPOCH_YEAR  = 11'd1978;
  localparam logic [YEAR_W-1:0] FIRST_YEAR  = 11'd1996;
  localparam logic [YEAR_W-1:0] LAST_YEAR   = 11'd2037;
  localparam logic [MON_W-1:0]  LAST_MONTH  = 4'd12;
  localparam logic [SEC_W-1:0]  SEC_MAX     = 6'd59;
  localparam logic [MOD_W-1:0]  HOUR_RECIP  = 11'd1093;
  localparam int unsigned       HOUR_SHIFT  = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADJ,
    ST_HMS,
    ST_MIN,
    ST_YEAR,
    ST_MONTH,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic              valid_res;
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DOM_W-1:0]  day_of_month;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [WDAY_W-1:0] weekday;
  } result_t;

  // exact over the walked span 1978..2037, whose only century year is 2000
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    return y[1:0] == 2'b00;
  endfunction

  function automatic logic [DOM_W-1:0] month_len(input logic [MON_W-1:0] mon,
                                                 input logic leap);
    logic [DOM_W-1:0] len;
    unique case (mon)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [WDAY_W-1:0] wday_add(input logic [WDAY_W-1:0] w,
                                                 input logic [WDAY_W-1:0] a);
    logic [WDAY_W:0] s;
    s = {1'b0, w} + {1'b0, a};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[WDAY_W-1:0];
  endfunction

  function automatic logic [WDAY_W-1:0] mod7_small(input logic [DOM_W-1:0] d);
    logic [DOM_W-1:0] r;
    r = d;
    if (r >= 5'd28) begin
      r = r - 5'd28;
    end
    if (r >= 5'd14) begin
      r = r - 5'd14;
    end
    if (r >= 5'd7) begin
      r = r - 5'd7;
    end
    return r[WDAY_W-1:0];
  endfunction

endpackage

[hdl/dtc_if.sv]
// Valid/ready channel interfaces of the date stamp to calendar fields block:
// request, result and configuration write channels.
// Depends on dtc_pkg for field widths.
interface dtc_in_if import dtc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DAY_W-1:0]  day_count;
  logic [MOD_W-1:0]  minute_of_day;
  logic [TICK_W-1:0] tick_in_minute;
  logic              time_unset;
  logic [BLEN_W-1:0] buffer_length;

  modport source (output valid, day_count, minute_of_day, tick_in_minute, time_unset,
                  buffer_length, input ready);
  modport sink   (input valid, day_count, minute_of_day, tick_in_minute, time_unset,
                  buffer_length, output ready);
endinterface

interface dtc_out_if import dtc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              valid_res;
  logic [YEAR_W-1:0] year;
  logic [MON_W-1:0]  month;
  logic [DOM_W-1:0]  day_of_month;
  logic [HOUR_W-1:0] hour;
  logic [MIN_W-1:0]  minute;
  logic [SEC_W-1:0]  second;
  logic [WDAY_W-1:0] weekday;

  modport source (output valid, valid_res, year, month, day_of_month, hour, minute,
                  second, weekday, input ready);
  modport sink   (input valid, valid_res, year, month, day_of_month, hour, minute,
                  second, weekday, output ready);
endinterface

interface dtc_cfg_if import dtc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [TZ_W-1:0] tz_offset_minutes;

  modport source (output valid, tz_offset_minutes, input ready);
  modport sink   (input valid, tz_offset_minutes, output ready);
endinterface

[hdl/datestamp_to_calendar_fields.sv]
// Date stamp to calendar fields: top level, one shared subtract/compare unit
// under a small sequencer. Depends on dtc_pkg and the channels in dtc_if.
// Requests that the flags, buffer length or minute reject go straight from the
// idle state to the final state; others pass the offset adjust, hour, minute,
// year walk (a year at a time from 1978) and month walk (a month at a time).
// One request at a time; the next is taken the cycle after the result is
// registered. rst_ni clears the sequencer, the result valid and the offset (0).
module datestamp_to_calendar_fields import dtc_pkg::*; #(
  parameter int unsigned TICKS_PER_SEC = 50
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtc_cfg_if.sink   cfg_i,
  dtc_in_if.sink    in_i,
  dtc_out_if.source out_o
);

  localparam int unsigned SEC_L     = $clog2(TICKS_PER_SEC);
  localparam int unsigned SEC_K     = TICK_W + SEC_L;
  localparam int unsigned SEC_RECIP = ((1 << SEC_K) + TICKS_PER_SEC - 1) / TICKS_PER_SEC;
  localparam int unsigned RECIP_W   = TICK_W + 2;
  localparam int unsigned SPROD_W   = TICK_W + RECIP_W;

  localparam logic signed [ACC_W-1:0] DAY_MIN_S = ACC_W'(MIN_PER_DAY);

  state_e state_q, state_d;
  logic                   out_valid_q, out_valid_d;
  logic signed [TZ_W-1:0] tz_q;
  result_t                res_q, res_d;

  logic signed [ACC_W-1:0] days_q, days_d;
  logic signed [ACC_W-1:0] r_q, r_d;
  logic                    bad_q, bad_d;
  logic [SEC_W-1:0]        sec_q, sec_d;
  logic [HOUR_W-1:0]       hour_q, hour_d;
  logic [MIN_W-1:0]        minute_q, minute_d;
  logic [YEAR_W-1:0]       year_q, year_d;
  logic [MON_W-1:0]        mon_q, mon_d;
  logic [WDAY_W-1:0]       wd_q, wd_d;

  logic signed [ACC_W-1:0] acc_a, acc_b, acc_diff;
  logic                    acc_neg;
  logic [SPROD_W-1:0]      sec_prod, sec_full;
  logic [2*MOD_W-1:0]      hour_prod;
  logic [MOD_W-1:0]        hour60;
  logic                    leap;
  logic [DOM_W-1:0]        mlen;

  assign acc_diff = acc_a - acc_b;
  assign acc_neg  = acc_diff[ACC_W-1];

  assign sec_prod  = SPROD_W'(in_i.tick_in_minute) * SPROD_W'(RECIP_W'(SEC_RECIP));
  assign sec_full  = sec_prod >> SEC_K;
  assign hour_prod = {{MOD_W{1'b0}}, r_q[MOD_W-1:0]} * {{MOD_W{1'b0}}, HOUR_RECIP};
  assign hour60    = (MOD_W'(hour_q) << 6) - (MOD_W'(hour_q) << 2);
  assign leap      = is_leap(year_q);
  assign mlen      = month_len(mon_q, leap);

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);

  assign out_o.valid        = out_valid_q;
  assign out_o.valid_res    = res_q.valid_res;
  assign out_o.year         = res_q.year;
  assign out_o.month        = res_q.month;
  assign out_o.day_of_month = res_q.day_of_month;
  assign out_o.hour         = res_q.hour;
  assign out_o.minute       = res_q.minute;
  assign out_o.second       = res_q.second;
  assign out_o.weekday      = res_q.weekday;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    days_d      = days_q;
    r_d         = r_q;
    bad_d       = bad_q;
    sec_d       = sec_q;
    hour_d      = hour_q;
    minute_d    = minute_q;
    year_d      = year_q;
    mon_d       = mon_q;
    wd_d        = wd_q;
    acc_a       = r_q;
    acc_b       = DAY_MIN_S;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        acc_a = ACC_W'(in_i.minute_of_day);
        acc_b = ACC_W'(tz_q);
        if (in_i.valid) begin
          days_d = ACC_W'(in_i.day_count);
          r_d    = acc_diff;
          bad_d  = in_i.time_unset || (in_i.buffer_length < BLEN_MIN) ||
                   (in_i.minute_of_day > MOD_MAX);
          sec_d  = (sec_full > SPROD_W'(SEC_MAX)) ? SEC_MAX : sec_full[SEC_W-1:0];
          state_d = bad_d ? ST_FIN : ST_ADJ;
        end
      end
      ST_ADJ: begin
        acc_a = r_q;
        acc_b = r_q[ACC_W-1] ? -DAY_MIN_S : DAY_MIN_S;
        if (r_q[ACC_W-1]) begin
          r_d    = acc_diff;
          days_d = days_q - ACC_W'(1);
        end else if (!acc_neg) begin
          r_d    = acc_diff;
          days_d = days_q + ACC_W'(1);
        end else if (days_q[ACC_W-1]) begin
          bad_d   = 1'b1;
          state_d = ST_FIN;
        end else begin
          state_d = ST_HMS;
        end
      end
      ST_HMS: begin
        hour_d  = hour_prod[HOUR_SHIFT +: HOUR_W];
        state_d = ST_MIN;
      end
      ST_MIN: begin
        minute_d = MIN_W'(r_q[MOD_W-1:0] - hour60);
        year_d   = EPOCH_YEAR;
        wd_d     = '0;
        state_d  = ST_YEAR;
      end
      ST_YEAR: begin
        acc_a = days_q;
        acc_b = leap ? ACC_W'(366) : ACC_W'(365);
        if (acc_neg) begin
          mon_d   = 4'd1;
          state_d = ST_MONTH;
        end else if (year_q >= LAST_YEAR) begin
          bad_d   = 1'b1;
          state_d = ST_FIN;
        end else begin
          days_d = acc_diff;
          year_d = YEAR_W'(year_q + 11'd1);
          wd_d   = wday_add(wd_q, leap ? 3'd2 : 3'd1);
        end
      end
      ST_MONTH: begin
        acc_a = days_q;
        acc_b = ACC_W'(mlen);
        if (acc_neg || (mon_q >= LAST_MONTH)) begin
          state_d = ST_FIN;
        end else begin
          days_d = acc_diff;
          mon_d  = MON_W'(mon_q + 4'd1);
          wd_d   = wday_add(wd_q, WDAY_W'(mlen - 5'd28));
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (bad_q || (year_q < FIRST_YEAR)) begin
            res_d = '0;
          end else begin
            res_d.valid_res    = 1'b1;
            res_d.year         = year_q;
            res_d.month        = mon_q;
            res_d.day_of_month = DOM_W'(days_q[DOM_W-1:0] + 5'd1);
            res_d.hour         = hour_q;
            res_d.minute       = minute_q;
            res_d.second       = sec_q;
            res_d.weekday      = wday_add(wd_q, mod7_small(days_q[DOM_W-1:0]));
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      tz_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        tz_q <= cfg_i.tz_offset_minutes;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    days_q   <= days_d;
    r_q      <= r_d;
    bad_q    <= bad_d;
    sec_q    <= sec_d;
    hour_q   <= hour_d;
    minute_q <= minute_d;
    year_q   <= year_d;
    mon_q    <= mon_d;
    wd_q     <= wd_d;
  end

endmodule

[hdl/dtc_checker.sv]
// Port-level checker for datestamp_to_calendar_fields, with its bind.
// Depends on dtc_pkg for field widths and calendar bounds.
module dtc_checker import dtc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              valid_res_i,
  input logic [YEAR_W-1:0] year_i,
  input logic [MON_W-1:0]  month_i,
  input logic [DOM_W-1:0]  day_of_month_i,
  input logic [HOUR_W-1:0] hour_i,
  input logic [MIN_W-1:0]  minute_i,
  input logic [SEC_W-1:0]  second_i,
  input logic [WDAY_W-1:0] weekday_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while a conversion is running");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !valid_res_i |->
      year_i == '0 && month_i == '0 && day_of_month_i == '0 && hour_i == '0 &&
      minute_i == '0 && second_i == '0 && weekday_i == '0)
    else $error("rejected result carries nonzero fields");

  a_fields_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && valid_res_i |->
      year_i >= FIRST_YEAR && year_i <= LAST_YEAR && month_i >= 4'd1 &&
      month_i <= LAST_MONTH && day_of_month_i >= 5'd1 && hour_i < 5'd24 &&
      minute_i < 6'd60 && second_i <= SEC_MAX && weekday_i < 3'd7)
    else $error("result field out of calendar range");

endmodule

bind datestamp_to_calendar_fields dtc_checker u_dtc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .valid_res_i    (out_o.valid_res),
  .year_i         (out_o.year),
  .month_i        (out_o.month),
  .day_of_month_i (out_o.day_of_month),
  .hour_i         (out_o.hour),
  .minute_i       (out_o.minute),
  .second_i       (out_o.second),
  .weekday_i      (out_o.weekday)
);
